[design/qtcq_pkg.sv]
// shared types for the quadrant two-color quantizer pipeline
`timescale 1ns / 1ps

package qtcq_pkg;

   localparam int ChannelBits = 8;
   localparam int Pixels = 4;
   localparam int Channels = 3;
   localparam int LumaBits = ChannelBits + 2;
   localparam int CountBits = 3;
   localparam int GlyphBits = 4;

   typedef logic [ChannelBits-1:0] chan_type;
   typedef logic [LumaBits-1:0] luma_type;
   typedef logic [CountBits-1:0] count_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   typedef struct packed {
      chan_type top_left_red;
      chan_type top_left_green;
      chan_type top_left_blue;
      chan_type top_right_red;
      chan_type top_right_green;
      chan_type top_right_blue;
      chan_type bottom_left_red;
      chan_type bottom_left_green;
      chan_type bottom_left_blue;
      chan_type bottom_right_red;
      chan_type bottom_right_green;
      chan_type bottom_right_blue;
   } req_type;

   typedef struct packed {
      logic [GlyphBits-1:0] glyph_index;
      chan_type fore_red;
      chan_type fore_green;
      chan_type fore_blue;
      chan_type back_red;
      chan_type back_green;
      chan_type back_blue;
   } rsp_type;

   // pixel index 0..3 is TL, TR, BL, BR; channel index 0..2 is red, green, blue
   typedef struct packed {
      pixel_type [Pixels-1:0] px;
      luma_type [Pixels-1:0] bright;
   } luma_stage_type;

   typedef struct packed {
      pixel_type [Pixels-1:0] px;
      logic [GlyphBits-1:0] glyph;
   } split_stage_type;

   typedef struct packed {
      logic [GlyphBits-1:0] glyph;
      count_type fore_count;
      count_type back_count;
      luma_type [Channels-1:0] fore_sum;
      luma_type [Channels-1:0] back_sum;
   } accum_stage_type;

endpackage

[design/qtcq_luma.sv]
// stage one: unpack the cell and form each pixel's brightness
`timescale 1ns / 1ps

module qtcq_luma (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  qtcq_pkg::req_type        in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output qtcq_pkg::luma_stage_type out_data
);

   logic valid_ff;
   qtcq_pkg::luma_stage_type data_ff, data_in;

   always_comb begin
      data_in.px[0] = '{in_data.top_left_red, in_data.top_left_green,
                        in_data.top_left_blue};
      data_in.px[1] = '{in_data.top_right_red, in_data.top_right_green,
                        in_data.top_right_blue};
      data_in.px[2] = '{in_data.bottom_left_red, in_data.bottom_left_green,
                        in_data.bottom_left_blue};
      data_in.px[3] = '{in_data.bottom_right_red, in_data.bottom_right_green,
                        in_data.bottom_right_blue};
      for (int p = 0; p < qtcq_pkg::Pixels; p++) begin
         data_in.bright[p] = {2'b00, data_in.px[p].red}
                           + {2'b00, data_in.px[p].green}
                           + {2'b00, data_in.px[p].blue};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

[design/qtcq_split.sv]
// stage two: brightness range and foreground/background split
`timescale 1ns / 1ps

module qtcq_split (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  qtcq_pkg::luma_stage_type  in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output qtcq_pkg::split_stage_type out_data
);

   logic valid_ff;
   qtcq_pkg::split_stage_type data_ff, data_in;
   qtcq_pkg::luma_type hi_a, hi_b, lo_a, lo_b, hi, lo;
   logic [qtcq_pkg::LumaBits:0] range_sum;

   always_comb begin
      // two-level compare tree for max and min
      hi_a = (in_data.bright[1] > in_data.bright[0]) ? in_data.bright[1] : in_data.bright[0];
      hi_b = (in_data.bright[3] > in_data.bright[2]) ? in_data.bright[3] : in_data.bright[2];
      lo_a = (in_data.bright[1] < in_data.bright[0]) ? in_data.bright[1] : in_data.bright[0];
      lo_b = (in_data.bright[3] < in_data.bright[2]) ? in_data.bright[3] : in_data.bright[2];
      hi = (hi_b > hi_a) ? hi_b : hi_a;
      lo = (lo_b < lo_a) ? lo_b : lo_a;
      range_sum = {1'b0, hi} + {1'b0, lo};
      data_in.px = in_data.px;
      for (int p = 0; p < qtcq_pkg::Pixels; p++) begin
         data_in.glyph[p] = {in_data.bright[p], 1'b0} > range_sum;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

[design/qtcq_accum.sv]
// stage three: per-group channel sums and pixel counts
`timescale 1ns / 1ps

module qtcq_accum (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  qtcq_pkg::split_stage_type in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output qtcq_pkg::accum_stage_type out_data
);

   logic valid_ff;
   qtcq_pkg::accum_stage_type data_ff, data_in;
   qtcq_pkg::chan_type [qtcq_pkg::Channels-1:0] chan;

   always_comb begin
      data_in.glyph = in_data.glyph;
      data_in.fore_count = '0;
      data_in.back_count = '0;
      data_in.fore_sum = '0;
      data_in.back_sum = '0;
      for (int p = 0; p < qtcq_pkg::Pixels; p++) begin
         chan[0] = in_data.px[p].red;
         chan[1] = in_data.px[p].green;
         chan[2] = in_data.px[p].blue;
         if (in_data.glyph[p]) begin
            data_in.fore_count = data_in.fore_count + 3'd1;
         end else begin
            data_in.back_count = data_in.back_count + 3'd1;
         end
         for (int c = 0; c < qtcq_pkg::Channels; c++) begin
            if (in_data.glyph[p]) begin
               data_in.fore_sum[c] = data_in.fore_sum[c] + {2'b00, chan[c]};
            end else begin
               data_in.back_sum[c] = data_in.back_sum[c] + {2'b00, chan[c]};
            end
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

[design/qtcq_average.sv]
// stage four: group averages by small constant division, output register
`timescale 1ns / 1ps

module qtcq_average (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  qtcq_pkg::accum_stage_type in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output qtcq_pkg::rsp_type         out_data
);

   localparam int RecipBits = 11;
   localparam int Recip3 = 683;  // ceil(2^11 / 3), exact for sums below 2046
   localparam int ProdBits = qtcq_pkg::LumaBits + RecipBits;

   logic valid_ff;
   qtcq_pkg::rsp_type data_ff, data_in;

   function automatic qtcq_pkg::chan_type group_average(qtcq_pkg::luma_type sum,
                                                        qtcq_pkg::count_type count);
      logic [ProdBits-1:0] prod;
      qtcq_pkg::chan_type result;
      prod = {{RecipBits{1'b0}}, sum} * ProdBits'(Recip3);
      case (count)
         3'd1: result = sum[qtcq_pkg::ChannelBits-1:0];
         3'd2: result = sum[qtcq_pkg::ChannelBits:1];
         3'd3: result = prod[RecipBits+qtcq_pkg::ChannelBits-1:RecipBits];
         3'd4: result = sum[qtcq_pkg::ChannelBits+1:2];
         default: result = '0;  // empty group
      endcase
      return result;
   endfunction

   always_comb begin
      data_in.glyph_index = in_data.glyph;
      data_in.fore_red = group_average(in_data.fore_sum[0], in_data.fore_count);
      data_in.fore_green = group_average(in_data.fore_sum[1], in_data.fore_count);
      data_in.fore_blue = group_average(in_data.fore_sum[2], in_data.fore_count);
      data_in.back_red = group_average(in_data.back_sum[0], in_data.back_count);
      data_in.back_green = group_average(in_data.back_sum[1], in_data.back_count);
      data_in.back_blue = group_average(in_data.back_sum[2], in_data.back_count);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

[design/quadrant_two_color_quantizer.sv]
// top level of the quadrant two-color quantizer
// Takes one 2x2 cell of 8-bit RGB pixels per word on the req_ channel and
// returns one word on the rsp_ channel: a 4-bit quadrant glyph index (bit i
// set when pixel i of TL, TR, BL, BR is brighter than the cell's mid level)
// and the truncated average color of the foreground and background pixels.
// An empty foreground gives zero colors.
// A word is taken when valid is high and stall is low on that channel.
// Four register stages: brightness, split, group sums, averages. The first
// captures the word at the accepting edge, then the word moves on through
// the split, group-sum and average registers in turn. Throughput is one
// cell per cycle while rsp_stall is low, with no dependence between cells.
// rsp_valid comes straight from the output register. When the receiver
// stalls, the output holds and the stages behind it keep filling until
// each holds a word; only then does req_stall rise. Empty stages never
// stall the input.
// Reset clears all stage valid bits; the stage data registers are not reset.
`timescale 1ns / 1ps

module quadrant_two_color_quantizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qtcq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qtcq_pkg::rsp_type rsp_data
);

   logic luma_valid, luma_ready;
   logic split_valid, split_ready;
   logic accum_valid, accum_ready;
   qtcq_pkg::luma_stage_type luma_data;
   qtcq_pkg::split_stage_type split_data;
   qtcq_pkg::accum_stage_type accum_data;
   logic req_ready;

   qtcq_luma u_luma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (luma_valid),
      .out_ready (luma_ready),
      .out_data  (luma_data)
   );

   qtcq_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (luma_valid),
      .in_ready  (luma_ready),
      .in_data   (luma_data),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_data  (split_data)
   );

   qtcq_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_data   (split_data),
      .out_valid (accum_valid),
      .out_ready (accum_ready),
      .out_data  (accum_data)
   );

   qtcq_average u_average (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accum_valid),
      .in_ready  (accum_ready),
      .in_data   (accum_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

   assign req_stall = !req_ready;

   // the darkest pixel always lands in the background
   a_glyph_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.glyph_index != 4'hF)
      else $error("glyph marks every pixel as foreground");

   a_empty_fore_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.glyph_index == 4'h0) |->
      (rsp_data.fore_red == '0 && rsp_data.fore_green == '0 && rsp_data.fore_blue == '0))
      else $error("empty foreground with nonzero color");

   // a draining output means every stage can advance
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

   a_accept_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("accepted word lost in pipeline");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output valid right after reset");

endmodule

[test/quantizer_checker.sv]
// watches both channels of the quantizer, predicts each cell's result and compares
`timescale 1ns / 1ps

module quantizer_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  qtcq_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  qtcq_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                pending_count
);

   qtcq_pkg::rsp_type expected_cells[$];
   qtcq_pkg::rsp_type want;

   function automatic qtcq_pkg::chan_type group_mean(int unsigned sum, int unsigned count);
      if (count == 0) begin
         return '0;
      end
      return qtcq_pkg::chan_type'(sum / count);
   endfunction

   function automatic qtcq_pkg::rsp_type quantize_cell(qtcq_pkg::req_type quad);
      int unsigned chan [qtcq_pkg::Pixels][qtcq_pkg::Channels];
      int unsigned bright [qtcq_pkg::Pixels];
      int unsigned fore_sum [qtcq_pkg::Channels];
      int unsigned back_sum [qtcq_pkg::Channels];
      int unsigned hi;
      int unsigned lo;
      int unsigned fore_count;
      int unsigned back_count;
      qtcq_pkg::rsp_type result;
      chan[0][0] = quad.top_left_red;
      chan[0][1] = quad.top_left_green;
      chan[0][2] = quad.top_left_blue;
      chan[1][0] = quad.top_right_red;
      chan[1][1] = quad.top_right_green;
      chan[1][2] = quad.top_right_blue;
      chan[2][0] = quad.bottom_left_red;
      chan[2][1] = quad.bottom_left_green;
      chan[2][2] = quad.bottom_left_blue;
      chan[3][0] = quad.bottom_right_red;
      chan[3][1] = quad.bottom_right_green;
      chan[3][2] = quad.bottom_right_blue;
      hi = 0;
      lo = 0;
      fore_count = 0;
      back_count = 0;
      result = '0;
      for (int c = 0; c < qtcq_pkg::Channels; c++) begin
         fore_sum[c] = 0;
         back_sum[c] = 0;
      end
      for (int p = 0; p < qtcq_pkg::Pixels; p++) begin
         bright[p] = chan[p][0] + chan[p][1] + chan[p][2];
         if (p == 0 || bright[p] > hi) begin
            hi = bright[p];
         end
         if (p == 0 || bright[p] < lo) begin
            lo = bright[p];
         end
      end
      // foreground sits strictly above the cell's mid level
      for (int p = 0; p < qtcq_pkg::Pixels; p++) begin
         if (2 * bright[p] > hi + lo) begin
            result.glyph_index[p] = 1'b1;
            fore_count++;
            for (int c = 0; c < qtcq_pkg::Channels; c++) fore_sum[c] += chan[p][c];
         end else begin
            back_count++;
            for (int c = 0; c < qtcq_pkg::Channels; c++) back_sum[c] += chan[p][c];
         end
      end
      result.fore_red = group_mean(fore_sum[0], fore_count);
      result.fore_green = group_mean(fore_sum[1], fore_count);
      result.fore_blue = group_mean(fore_sum[2], fore_count);
      result.back_red = group_mean(back_sum[0], back_count);
      result.back_green = group_mean(back_sum[1], back_count);
      result.back_blue = group_mean(back_sum[2], back_count);
      return result;
   endfunction

   task automatic check_field(string name, int unsigned expected, int unsigned actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         error_count++;
      end
   endtask

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_cells.push_back(quantize_cell(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               $error("result word with no cell waiting: glyph_index %0d",
                      rsp_data.glyph_index);
               error_count++;
            end else begin
               want = expected_cells.pop_front();
               check_field("glyph_index", want.glyph_index, rsp_data.glyph_index);
               check_field("fore_red", want.fore_red, rsp_data.fore_red);
               check_field("fore_green", want.fore_green, rsp_data.fore_green);
               check_field("fore_blue", want.fore_blue, rsp_data.fore_blue);
               check_field("back_red", want.back_red, rsp_data.back_red);
               check_field("back_green", want.back_green, rsp_data.back_green);
               check_field("back_blue", want.back_blue, rsp_data.back_blue);
            end
         end
         pending_count = expected_cells.size();
      end
   end

endmodule

[test/testbench.sv]
// stimulus and verdict for the quadrant two-color quantizer
`timescale 1ns / 1ps

module testbench;

   typedef enum logic [1:0] {
      PHASE_SENDER_LIGHT,
      PHASE_RECEIVER_LIGHT,
      PHASE_QUIET
   } idle_phase_type;

   localparam qtcq_pkg::pixel_type White = '{8'hff, 8'hff, 8'hff};
   localparam qtcq_pkg::pixel_type Black = '{8'h00, 8'h00, 8'h00};
   localparam int RandomPerPhase = 180;
   localparam int HoldCycles = 80;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   qtcq_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   qtcq_pkg::rsp_type rsp_data;
   idle_phase_type    phase;
   int                error_count;
   int                pending_count;

   quadrant_two_color_quantizer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   quantizer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("testbench: errors");
      $finish;
   end

   function automatic qtcq_pkg::pixel_type rgb(int r, int g, int b);
      return {8'(r), 8'(g), 8'(b)};
   endfunction

   function automatic qtcq_pkg::req_type make_cell(qtcq_pkg::pixel_type tl,
                                                   qtcq_pkg::pixel_type tr,
                                                   qtcq_pkg::pixel_type bl,
                                                   qtcq_pkg::pixel_type br);
      return {tl, tr, bl, br};
   endfunction

   // styles: full random, near a common level, uniform, extremes only
   function automatic qtcq_pkg::req_type random_cell();
      qtcq_pkg::pixel_type px [qtcq_pkg::Pixels];
      int style;
      int level;
      style = $urandom_range(9);
      level = $urandom_range(252);
      for (int p = 0; p < qtcq_pkg::Pixels; p++) begin
         if (style < 4) begin
            px[p] = qtcq_pkg::pixel_type'($urandom);
         end else if (style < 7) begin
            px[p] = rgb(level + $urandom_range(3), level + $urandom_range(3),
                        level + $urandom_range(3));
         end else if (style < 8) begin
            px[p] = (p == 0) ? qtcq_pkg::pixel_type'($urandom) : px[0];
         end else begin
            px[p] = rgb($urandom_range(1) * 255, $urandom_range(1) * 255,
                        $urandom_range(1) * 255);
         end
      end
      return make_cell(px[0], px[1], px[2], px[3]);
   endfunction

   task automatic send_cell(input qtcq_pkg::req_type word);
      int idle_pct;
      idle_pct = (phase == PHASE_SENDER_LIGHT) ? 10 :
                 (phase == PHASE_RECEIVER_LIGHT) ? 56 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= word;
      do @(posedge clock); while (req_stall);
   endtask

   // receiver: random stall per phase, one long hold when the quiet phase opens
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase == PHASE_QUIET && !hold_done) begin
            hold_left = HoldCycles;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < ((phase == PHASE_SENDER_LIGHT) ? 56 :
                          (phase == PHASE_RECEIVER_LIGHT) ? 10 : 0));
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      phase <= PHASE_SENDER_LIGHT;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // uniform cells leave the foreground empty
      send_cell(make_cell(Black, Black, Black, Black));
      send_cell(make_cell(White, White, White, White));
      send_cell(make_cell(rgb(128, 64, 32), rgb(128, 64, 32), rgb(128, 64, 32),
                          rgb(128, 64, 32)));
      // one bright pixel, then one dark pixel, at each position, then two-two splits
      send_cell(make_cell(White, Black, Black, Black));
      send_cell(make_cell(Black, White, Black, Black));
      send_cell(make_cell(Black, Black, White, Black));
      send_cell(make_cell(Black, Black, Black, White));
      send_cell(make_cell(Black, White, White, White));
      send_cell(make_cell(White, Black, White, White));
      send_cell(make_cell(White, White, Black, White));
      send_cell(make_cell(White, White, White, Black));
      send_cell(make_cell(White, Black, Black, White));
      send_cell(make_cell(White, White, Black, Black));
      // smallest brightness step and an exact tie with the mid level
      send_cell(make_cell(Black, Black, rgb(0, 0, 1), Black));
      send_cell(make_cell(Black, rgb(2, 0, 0), rgb(1, 0, 0), rgb(0, 0, 1)));
      send_cell(make_cell(rgb(170, 170, 170), rgb(85, 85, 85), rgb(85, 170, 85),
                          rgb(170, 85, 170)));
      send_cell(make_cell(rgb(255, 0, 0), rgb(0, 255, 0), rgb(0, 0, 255), White));
      // averages that truncate
      send_cell(make_cell(rgb(255, 254, 253), rgb(254, 253, 252), rgb(253, 1, 0), Black));
      send_cell(make_cell(White, White, rgb(0, 0, 1), rgb(254, 255, 254)));
      send_cell(make_cell(rgb(1, 2, 3), rgb(4, 5, 6), rgb(7, 8, 9), rgb(10, 11, 12)));

      for (int k = 0; k < RandomPerPhase; k++) send_cell(random_cell());
      phase <= PHASE_RECEIVER_LIGHT;
      for (int k = 0; k < RandomPerPhase; k++) send_cell(random_cell());
      phase <= PHASE_QUIET;
      for (int k = 0; k < RandomPerPhase; k++) send_cell(random_cell());
      req_valid <= 1'b0;

      do @(negedge clock); while (pending_count != 0);
      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

[sim.f]
design/qtcq_pkg.sv
design/qtcq_luma.sv
design/qtcq_split.sv
design/qtcq_accum.sv
design/qtcq_average.sv
design/quadrant_two_color_quantizer.sv
test/quantizer_checker.sv
test/testbench.sv
